// ===== design/y420rgb_pkg.sv =====
// Package for the 4:2:0 block to RGB converter: widths, BT.601 fixed point coefficients,
// the pipeline stage enable struct and the channel clamp function.
// No dependencies; used by y420rgb_pixel and yuv420_block_to_rgb.
package y420rgb_pkg;

    localparam int CHAN_W    = 8;
    localparam int FRAC_BITS = 10;
    // Signed width of one scaled term (luma or chroma part) and of their sum.
    localparam int TERM_W    = 20;
    localparam int SUM_W     = 21;

    localparam logic signed [SUM_W-1:0] COEF_Y     = 21'sd1192;
    localparam logic signed [SUM_W-1:0] COEF_RV    = 21'sd1634;
    localparam logic signed [SUM_W-1:0] COEF_GV    = 21'sd833;
    localparam logic signed [SUM_W-1:0] COEF_GU    = 21'sd400;
    localparam logic signed [SUM_W-1:0] COEF_BU    = 21'sd2066;
    localparam logic signed [SUM_W-1:0] LUMA_OFS   = 21'sd16;
    localparam logic signed [SUM_W-1:0] CHROMA_OFS = 21'sd128;
    localparam logic [CHAN_W-1:0]       CHAN_MAX   = 8'd255;

    // Load enables of the four register stages, one per stage.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    // Floor the scaled sum by 2^FRAC_BITS and clamp it to the channel range.
    function automatic logic [CHAN_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
        logic [CHAN_W-1:0] result;
        if (sum[SUM_W-1]) begin
            result = '0;
        end else if (|sum[SUM_W-2:FRAC_BITS+CHAN_W]) begin
            result = CHAN_MAX;
        end else begin
            result = sum[FRAC_BITS+CHAN_W-1:FRAC_BITS];
        end
        return result;
    endfunction

endpackage

// ===== design/y420rgb_pixel.sv =====
// One pixel lane of the converter: scaled luma, three channel sums and the clamp,
// spread over the same four register stages as the top level. Uses y420rgb_pkg.
module y420rgb_pixel (
    input  logic                                   aclk,
    input  y420rgb_pkg::stage_en_t                 en,
    input  logic [y420rgb_pkg::CHAN_W-1:0]         luma,
    input  logic signed [y420rgb_pkg::TERM_W-1:0]  rterm,
    input  logic signed [y420rgb_pkg::TERM_W-1:0]  gterm,
    input  logic signed [y420rgb_pkg::TERM_W-1:0]  bterm,
    output logic [y420rgb_pkg::CHAN_W-1:0]         red,
    output logic [y420rgb_pkg::CHAN_W-1:0]         green,
    output logic [y420rgb_pkg::CHAN_W-1:0]         blue
);

    logic signed [y420rgb_pkg::SUM_W-1:0]  luma_ext;
    logic signed [y420rgb_pkg::SUM_W-1:0]  ys_prod;
    logic signed [y420rgb_pkg::TERM_W-1:0] ys1_reg;
    logic signed [y420rgb_pkg::TERM_W-1:0] ys2_reg;
    logic signed [y420rgb_pkg::SUM_W-1:0]  ys_ext;
    logic signed [y420rgb_pkg::SUM_W-1:0]  r_sum_next;
    logic signed [y420rgb_pkg::SUM_W-1:0]  g_sum_next;
    logic signed [y420rgb_pkg::SUM_W-1:0]  b_sum_next;
    logic signed [y420rgb_pkg::SUM_W-1:0]  r_sum_reg;
    logic signed [y420rgb_pkg::SUM_W-1:0]  g_sum_reg;
    logic signed [y420rgb_pkg::SUM_W-1:0]  b_sum_reg;
    logic [y420rgb_pkg::CHAN_W-1:0]        red_reg;
    logic [y420rgb_pkg::CHAN_W-1:0]        green_reg;
    logic [y420rgb_pkg::CHAN_W-1:0]        blue_reg;

    assign luma_ext = $signed({{(y420rgb_pkg::SUM_W-y420rgb_pkg::CHAN_W){1'b0}}, luma})
                      - y420rgb_pkg::LUMA_OFS;
    assign ys_prod  = y420rgb_pkg::COEF_Y * luma_ext;
    assign ys_ext   = {ys2_reg[y420rgb_pkg::TERM_W-1], ys2_reg};

    assign r_sum_next = ys_ext + {rterm[y420rgb_pkg::TERM_W-1], rterm};
    assign g_sum_next = ys_ext + {gterm[y420rgb_pkg::TERM_W-1], gterm};
    assign b_sum_next = ys_ext + {bterm[y420rgb_pkg::TERM_W-1], bterm};

    // Payload registers only; the valid bits live in the top level.
    always_ff @(posedge aclk) begin
        if (en.s1) begin
            ys1_reg <= ys_prod[y420rgb_pkg::TERM_W-1:0];
        end
        if (en.s2) begin
            ys2_reg <= ys1_reg;
        end
        if (en.s3) begin
            r_sum_reg <= r_sum_next;
            g_sum_reg <= g_sum_next;
            b_sum_reg <= b_sum_next;
        end
        if (en.s4) begin
            red_reg   <= y420rgb_pkg::clamp_channel(r_sum_reg);
            green_reg <= y420rgb_pkg::clamp_channel(g_sum_reg);
            blue_reg  <= y420rgb_pkg::clamp_channel(b_sum_reg);
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

// ===== design/yuv420_block_to_rgb.sv =====
// Top level of the 4:2:0 2x2 block to RGB converter (BT.601 video range, fixed point).
// Depends on y420rgb_pkg and on y420rgb_pixel, one instance per pixel of the block.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------------------
//  s_      | in        | s_valid / s_ready  | four 8-bit luma samples, shared Cb and Cr
//  m_      | out       | m_valid / m_ready  | 8-bit red, green, blue for each of four pixels
//
// A transaction on the input channel delivers its result transaction after it has passed the
// four register stages (multiply, green chroma term, channel sums, clamp) and the output
// side is ready. One block enters in every cycle for as long as m_ready
// is high. Each stage holds its data while the stage after it is full and stalled. The ready
// chain is combinational: an empty stage anywhere keeps s_ready high and absorbs the stall,
// and once all four stages are full s_ready falls in the same cycle as m_ready, so no
// transaction is lost or repeated.
// Reset (aresetn low at a clock edge) clears only the four stage valid bits.
module yuv420_block_to_rgb (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_y_top_left,
    input  logic [7:0] s_y_top_right,
    input  logic [7:0] s_y_bottom_left,
    input  logic [7:0] s_y_bottom_right,
    input  logic [7:0] s_chroma_blue,
    input  logic [7:0] s_chroma_red,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_red_top_left,
    output logic [7:0] m_green_top_left,
    output logic [7:0] m_blue_top_left,
    output logic [7:0] m_red_top_right,
    output logic [7:0] m_green_top_right,
    output logic [7:0] m_blue_top_right,
    output logic [7:0] m_red_bottom_left,
    output logic [7:0] m_green_bottom_left,
    output logic [7:0] m_blue_bottom_left,
    output logic [7:0] m_red_bottom_right,
    output logic [7:0] m_green_bottom_right,
    output logic [7:0] m_blue_bottom_right
);

    localparam int SW = y420rgb_pkg::SUM_W;
    localparam int TW = y420rgb_pkg::TERM_W;
    localparam int CW = y420rgb_pkg::CHAN_W;

    // Stage valid bits and the ready chain. A stage may load when it is empty or when
    // the stage behind it takes its content in the same cycle.
    logic valid1_reg, valid2_reg, valid3_reg, valid4_reg;
    logic ready1, ready2, ready3, ready4;
    y420rgb_pkg::stage_en_t en;

    assign ready4 = !valid4_reg || m_ready;
    assign ready3 = !valid3_reg || ready4;
    assign ready2 = !valid2_reg || ready3;
    assign ready1 = !valid1_reg || ready2;

    // Field order of the enable struct is s1 (MSB) down to s4.
    assign en = {ready1, ready2, ready3, ready4};

    assign s_ready = ready1;
    assign m_valid = valid4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end else begin
            if (ready1) begin
                valid1_reg <= s_valid;
            end
            if (ready2) begin
                valid2_reg <= valid1_reg;
            end
            if (ready3) begin
                valid3_reg <= valid2_reg;
            end
            if (ready4) begin
                valid4_reg <= valid3_reg;
            end
        end
    end

    // Chroma path. Stage 1 forms the four chroma products; stage 2 combines the two
    // green products so that the sum stage sees one term per channel, aligned with luma.
    logic signed [SW-1:0] cb_ext, cr_ext;
    logic signed [SW-1:0] rterm_prod, gv_prod, gu_prod, bterm_prod;
    logic signed [TW-1:0] rterm1_reg, gv1_reg, gu1_reg, bterm1_reg;
    logic signed [TW-1:0] rterm2_reg, gterm2_reg, bterm2_reg;
    logic signed [TW:0]   gterm_next;

    assign cb_ext = $signed({{(SW-CW){1'b0}}, s_chroma_blue}) - y420rgb_pkg::CHROMA_OFS;
    assign cr_ext = $signed({{(SW-CW){1'b0}}, s_chroma_red})  - y420rgb_pkg::CHROMA_OFS;

    assign rterm_prod = y420rgb_pkg::COEF_RV * cr_ext;
    assign gv_prod    = y420rgb_pkg::COEF_GV * cr_ext;
    assign gu_prod    = y420rgb_pkg::COEF_GU * cb_ext;
    assign bterm_prod = y420rgb_pkg::COEF_BU * cb_ext;

    assign gterm_next = -({gv1_reg[TW-1], gv1_reg} + {gu1_reg[TW-1], gu1_reg});

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            rterm1_reg <= rterm_prod[TW-1:0];
            gv1_reg    <= gv_prod[TW-1:0];
            gu1_reg    <= gu_prod[TW-1:0];
            bterm1_reg <= bterm_prod[TW-1:0];
        end
        if (en.s2) begin
            rterm2_reg <= rterm1_reg;
            gterm2_reg <= gterm_next[TW-1:0];
            bterm2_reg <= bterm1_reg;
        end
    end

    // Four pixel lanes share the chroma terms and the stage enables.
    y420rgb_pixel u_pix_tl (
        .aclk  (aclk),
        .en    (en),
        .luma  (s_y_top_left),
        .rterm (rterm2_reg),
        .gterm (gterm2_reg),
        .bterm (bterm2_reg),
        .red   (m_red_top_left),
        .green (m_green_top_left),
        .blue  (m_blue_top_left)
    );

    y420rgb_pixel u_pix_tr (
        .aclk  (aclk),
        .en    (en),
        .luma  (s_y_top_right),
        .rterm (rterm2_reg),
        .gterm (gterm2_reg),
        .bterm (bterm2_reg),
        .red   (m_red_top_right),
        .green (m_green_top_right),
        .blue  (m_blue_top_right)
    );

    y420rgb_pixel u_pix_bl (
        .aclk  (aclk),
        .en    (en),
        .luma  (s_y_bottom_left),
        .rterm (rterm2_reg),
        .gterm (gterm2_reg),
        .bterm (bterm2_reg),
        .red   (m_red_bottom_left),
        .green (m_green_bottom_left),
        .blue  (m_blue_bottom_left)
    );

    y420rgb_pixel u_pix_br (
        .aclk  (aclk),
        .en    (en),
        .luma  (s_y_bottom_right),
        .rterm (rterm2_reg),
        .gterm (gterm2_reg),
        .bterm (bterm2_reg),
        .red   (m_red_bottom_right),
        .green (m_green_bottom_right),
        .blue  (m_blue_bottom_right)
    );

    // With the output side ready the whole pipeline advances, so input is never refused.
    assert property (@(posedge aclk) disable iff (!aresetn) m_ready |-> s_ready)
        else $error("input refused while output side is ready");

    // Input is refused only when every stage is full and the output is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (valid1_reg && valid2_reg && valid3_reg && valid4_reg && !m_ready))
        else $error("input refused with a free pipeline stage");

    // An accepted transaction always lands in the first stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid1_reg)
        else $error("accepted transaction lost at stage one");

    // A held second stage keeps its chroma terms.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !ready2 |=> (valid2_reg && $stable(gterm2_reg) && $stable(rterm2_reg)))
        else $error("stalled stage two changed its content");

endmodule

// ===== dv/yuv420_block_to_rgb_checker.sv =====
`timescale 1ns / 100ps
// Checker for the 4:2:0 block to RGB converter: predicts the twelve clamped channels of every
// accepted block and compares them with each result transaction, in order.
// Stand-alone; watches the ports of yuv420_block_to_rgb and hands counts to the testbench top.
module yuv420_block_to_rgb_checker (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_y_top_left,
    input  logic [7:0] s_y_top_right,
    input  logic [7:0] s_y_bottom_left,
    input  logic [7:0] s_y_bottom_right,
    input  logic [7:0] s_chroma_blue,
    input  logic [7:0] s_chroma_red,

    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_red_top_left,
    input  logic [7:0] m_green_top_left,
    input  logic [7:0] m_blue_top_left,
    input  logic [7:0] m_red_top_right,
    input  logic [7:0] m_green_top_right,
    input  logic [7:0] m_blue_top_right,
    input  logic [7:0] m_red_bottom_left,
    input  logic [7:0] m_green_bottom_left,
    input  logic [7:0] m_blue_bottom_left,
    input  logic [7:0] m_red_bottom_right,
    input  logic [7:0] m_green_bottom_right,
    input  logic [7:0] m_blue_bottom_right,

    output int         fail_count,
    output int         blocks_pending
);

    // BT.601 video-range coefficients, scaled by 1024.
    localparam int LUMA_GAIN     = 1192;
    localparam int RED_FROM_CR   = 1634;
    localparam int GREEN_FROM_CR = 833;
    localparam int GREEN_FROM_CB = 400;
    localparam int BLUE_FROM_CB  = 2066;
    localparam int SCALE_SHIFT   = 10;
    localparam int LUMA_BLACK    = 16;
    localparam int CHROMA_ZERO   = 128;
    localparam int CHAN_TOP      = 255;

    // Channel index 0 is red, 1 green, 2 blue; pixel index 0 is top left, then top right,
    // bottom left and bottom right.
    typedef logic [7:0] chan_t;
    typedef chan_t [2:0] rgb_t;
    typedef rgb_t [3:0] rgb_block_t;

    rgb_block_t expected_rgb [$];
    string      pixel_name [4] = '{"top_left", "top_right", "bottom_left", "bottom_right"};
    string      chan_name [3]  = '{"red", "green", "blue"};

    function automatic rgb_block_t convert_block(input logic [3:0][7:0] luma,
                                                 input logic [7:0] cb, input logic [7:0] cr);
        rgb_block_t rgb;
        int         chroma_term [3];
        int         luma_term;
        int         sum;
        int         cb_ofs;
        int         cr_ofs;
        cb_ofs = int'(cb) - CHROMA_ZERO;
        cr_ofs = int'(cr) - CHROMA_ZERO;
        chroma_term[0] = RED_FROM_CR * cr_ofs;
        chroma_term[1] = -(GREEN_FROM_CR * cr_ofs) - GREEN_FROM_CB * cb_ofs;
        chroma_term[2] = BLUE_FROM_CB * cb_ofs;
        for (int p = 0; p < 4; p++) begin
            luma_term = LUMA_GAIN * (int'(luma[p]) - LUMA_BLACK);
            for (int c = 0; c < 3; c++) begin
                sum = luma_term + chroma_term[c];
                // Negative sums go to black; floored values past the top saturate.
                if (sum < 0) begin
                    rgb[p][c] = '0;
                end else if ((sum >>> SCALE_SHIFT) > CHAN_TOP) begin
                    rgb[p][c] = chan_t'(CHAN_TOP);
                end else begin
                    rgb[p][c] = chan_t'(sum >>> SCALE_SHIFT);
                end
            end
        end
        return rgb;
    endfunction

    always @(posedge aclk) begin
        rgb_block_t want;
        rgb_block_t got;
        if (!aresetn) begin
            fail_count     = 0;
            blocks_pending = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_blue_bottom_right, m_green_bottom_right, m_red_bottom_right,
                       m_blue_bottom_left,  m_green_bottom_left,  m_red_bottom_left,
                       m_blue_top_right,    m_green_top_right,    m_red_top_right,
                       m_blue_top_left,     m_green_top_left,     m_red_top_left};
                if (expected_rgb.size() == 0) begin
                    $display("%0t: result transaction with no block outstanding, expected none, got %h",
                             $time, got);
                    fail_count++;
                end else begin
                    want = expected_rgb.pop_front();
                    for (int p = 0; p < 4; p++) begin
                        for (int c = 0; c < 3; c++) begin
                            if (got[p][c] !== want[p][c]) begin
                                $display("%0t: %s_%s expected %0d, got %0d", $time,
                                         chan_name[c], pixel_name[p], want[p][c],
                                         got[p][c]);
                                fail_count++;
                            end
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_rgb.push_back(convert_block(
                    {s_y_bottom_right, s_y_bottom_left, s_y_top_right, s_y_top_left},
                    s_chroma_blue, s_chroma_red));
            end
            blocks_pending = expected_rgb.size();
        end
    end

endmodule

// ===== dv/yuv420_block_to_rgb_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for yuv420_block_to_rgb: clock, reset, block stimulus, output back-pressure,
// watchdog and verdict. Depends on the block and on yuv420_block_to_rgb_checker.
module yuv420_block_to_rgb_tb;

    localparam int RANDOM_BLOCKS  = 630;
    // The block has four register stages; the extra wait after the drain catches spurious results.
    localparam int DRAIN_CYCLES   = 16;
    // Longest correct silence is the long output hold-off plus a sparse-ready stretch, so
    // a silence as long as the watchdog limit without any transaction can only mean a hang.
    localparam int WATCHDOG_LIMIT = 1000;
    // The long hold-off starts once this many blocks have gone in, inside the random part.
    localparam int HOLDOFF_AT     = 150;
    localparam int HOLDOFF_CYCLES = 64;

    // One 2x2 block as it appears on the input channel.
    typedef struct packed {
        logic [7:0] y_top_left;
        logic [7:0] y_top_right;
        logic [7:0] y_bottom_left;
        logic [7:0] y_bottom_right;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } yuv_block_t;

    // Output back-pressure patterns; each phase picks one at random.
    typedef enum int {
        SINK_ALWAYS,
        SINK_COIN_FLIP,
        SINK_SPARSE,
        SINK_PERIODIC
    } sink_mode_t;

    logic       aclk = 1'b0;
    logic       aresetn;

    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_y_top_left;
    logic [7:0] s_y_top_right;
    logic [7:0] s_y_bottom_left;
    logic [7:0] s_y_bottom_right;
    logic [7:0] s_chroma_blue;
    logic [7:0] s_chroma_red;

    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_red_top_left;
    logic [7:0] m_green_top_left;
    logic [7:0] m_blue_top_left;
    logic [7:0] m_red_top_right;
    logic [7:0] m_green_top_right;
    logic [7:0] m_blue_top_right;
    logic [7:0] m_red_bottom_left;
    logic [7:0] m_green_bottom_left;
    logic [7:0] m_blue_bottom_left;
    logic [7:0] m_red_bottom_right;
    logic [7:0] m_green_bottom_right;
    logic [7:0] m_blue_bottom_right;

    int         fail_count;
    int         blocks_pending;
    int         blocks_sent = 0;
    int         quiet_cycles = 0;

    // Directed blocks: black and white points, exact zero sums, sums just below zero and just
    // past full scale, every chroma corner, mixed lumas in one block and alternating bit
    // patterns. Order of fields: four lumas (TL, TR, BL, BR), then Cb, then Cr.
    yuv_block_t directed_blocks [20] = '{
        '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
        '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
        '{8'd16,  8'd16,  8'd16,  8'd16,  8'd128, 8'd128},
        '{8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128},
        '{8'd236, 8'd255, 8'd15,  8'd0,   8'd128, 8'd128},
        '{8'd0,   8'd85,  8'd170, 8'd255, 8'd128, 8'd128},
        '{8'd128, 8'd128, 8'd128, 8'd128, 8'd0,   8'd0},
        '{8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd255},
        '{8'd128, 8'd128, 8'd128, 8'd128, 8'd0,   8'd255},
        '{8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd0},
        '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0},
        '{8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255},
        '{8'd16,  8'd17,  8'd234, 8'd235, 8'd127, 8'd129},
        '{8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0},
        '{8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255},
        '{8'h55,  8'haa,  8'h55,  8'haa,  8'h55,  8'haa},
        '{8'haa,  8'h55,  8'haa,  8'h55,  8'haa,  8'h55},
        '{8'd17,  8'd16,  8'd15,  8'd1,   8'd1,   8'd254},
        '{8'd100, 8'd150, 8'd200, 8'd50,  8'd90,  8'd240},
        '{8'd60,  8'd60,  8'd60,  8'd60,  8'd240, 8'd110}
    };

    yuv420_block_to_rgb dut (.*);

    yuv420_block_to_rgb_checker checker_i (.*);

    always #1 aclk = ~aclk;

    // Random block. Most are uniform; about a third pull fields from the values where the
    // equations cross zero or full scale, so the clamps are hit often.
    function automatic yuv_block_t random_block();
        logic [5:0][7:0] fields;
        logic [7:0]      corner [11] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd127, 8'd128,
                                         8'd234, 8'd235, 8'd236, 8'd255};
        bit              near_corner;
        near_corner = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < 6; i++) begin
            if (near_corner && $urandom_range(0, 1)) begin
                fields[i] = corner[$urandom_range(0, 10)];
            end else begin
                fields[i] = 8'($urandom);
            end
        end
        return yuv_block_t'(fields);
    endfunction

    // Offers one block from a falling edge, holds it until the rising edge that accepts it,
    // and returns on the falling edge after that, ready for the next block or a gap.
    task automatic send_block(input yuv_block_t blk);
        s_valid <= 1'b1;
        {s_y_top_left, s_y_top_right, s_y_bottom_left, s_y_bottom_right,
         s_chroma_blue, s_chroma_red} <= blk;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // A gap on the input side. The payload carries junk while valid is low, which the block
    // must ignore.
    task automatic idle_sender(input int cycles);
        s_valid <= 1'b0;
        {s_y_top_left, s_y_top_right, s_y_bottom_left, s_y_bottom_right,
         s_chroma_blue, s_chroma_red} <= random_block();
        repeat (cycles) @(negedge aclk);
    endtask

    // Counts accepted input blocks for the hold-off trigger, and ends the run when no
    // transaction has happened on either channel for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                blocks_sent++;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Output side. The receiver changes its stall pattern every phase, with whole phases of
    // no stalls at all, and once holds off for a long stretch so the pipeline fills and the
    // block has to drop s_ready while the sender keeps offering.
    initial begin
        sink_mode_t mode;
        int         phase_len;
        int         beat;
        bit         holdoff_done;
        holdoff_done = 1'b0;
        beat         = 0;
        m_ready      = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            mode      = sink_mode_t'($urandom_range(0, 3));
            phase_len = $urandom_range(20, 150);
            repeat (phase_len) begin
                if (!holdoff_done && blocks_sent >= HOLDOFF_AT) begin
                    holdoff_done = 1'b1;
                    repeat (HOLDOFF_CYCLES) begin
                        m_ready <= 1'b0;
                        @(negedge aclk);
                    end
                end
                case (mode)
                    SINK_ALWAYS: begin
                        m_ready <= 1'b1;
                    end
                    SINK_COIN_FLIP: begin
                        m_ready <= 1'($urandom_range(0, 1));
                    end
                    SINK_SPARSE: begin
                        m_ready <= ($urandom_range(0, 3) == 0);
                    end
                    SINK_PERIODIC: begin
                        m_ready <= ((beat % 5) < 3);
                    end
                    default: begin
                        m_ready <= 1'b1;
                    end
                endcase
                beat++;
                @(negedge aclk);
            end
        end
    end

    // Input side and verdict.
    initial begin
        int burst_left;
        burst_left       = 0;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_y_top_left     = '0;
        s_y_top_right    = '0;
        s_y_bottom_left  = '0;
        s_y_bottom_right = '0;
        s_chroma_blue    = '0;
        s_chroma_red     = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // The directed blocks go in back to back; the receiver still stalls at random.
        foreach (directed_blocks[i]) begin
            send_block(directed_blocks[i]);
        end

        // Random blocks in bursts of random length. Most bursts start after a short gap, the
        // rest follow the previous burst directly, so some stretches run with no gaps.
        for (int n = 0; n < RANDOM_BLOCKS; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0) begin
                    idle_sender($urandom_range(1, 8));
                end
            end
            send_block(random_block());
            burst_left--;
        end
        s_valid <= 1'b0;

        // Wait for every outstanding result, then a little longer so that any extra result
        // transaction would still be caught by the checker.
        while (blocks_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (fail_count == 0 && blocks_pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/y420rgb_pkg.sv
design/y420rgb_pixel.sv
design/yuv420_block_to_rgb.sv
dv/yuv420_block_to_rgb_checker.sv
dv/yuv420_block_to_rgb_tb.sv
